// ===== rtl/dtps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtps_pkg
// Types and constants shared by the depth-tested pixel store.
// ----------------------------------------------------------------------------
package dtps_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH_BITS = 24;

  localparam int X_BITS    = $clog2(MAX_WIDTH);
  localparam int Y_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = X_BITS + Y_BITS;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  localparam int SIZE_W  = 9;
  localparam int POS_W   = 10;
  localparam int COLOR_W = 32;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [7:0]            ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_ZWRITE  = 3'd1,
    FN_READ    = 3'd2,
    FN_CLR_COL = 3'd3,
    FN_CLR_Z   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OFF   = 2'd1,
    ST_ZFAIL = 2'd2,
    ST_NOZ   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1,
    REG_DEPTH_ENABLE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [COLOR_W-1:0]     color;
    logic [DEPTH_BITS-1:0]  depth;
  } result_t;

endpackage

// ===== rtl/depth_tested_pixel_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_unit
// Frame store of ARGB pixels with a depth buffer and a strict less-than test.
// ----------------------------------------------------------------------------
// Color and depth live in two single-port-write RAMs of 65536 entries, read at
// the address of each word when it is accepted; the next cycle compares,
// writes back and builds the result. A write, depth-tested write or read
// passes its result to the output register when that is free, else holds it in
// S_DONE. A color or depth clear walks the active area one pixel per cycle,
// with each size capped at 256. The input is stalled while a word is in work,
// so no new word is taken before the last one is through; a finished result
// waits in the output register without holding up acceptance of the next word,
// but one that finds that register still taken holds the input in S_DONE.
module depth_tested_pixel_store_unit
  import dtps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_func,
  input  logic [POS_W-1:0]       in_pos_x,
  input  logic [POS_W-1:0]       in_pos_y,
  input  logic [23:0]            in_new_depth,
  input  logic [7:0]             in_alpha,
  input  logic [7:0]             in_red,
  input  logic [7:0]             in_green,
  input  logic [7:0]             in_blue,
  input  logic [7:0]             in_shade,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [7:0]             out_alpha,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [23:0]            out_depth,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [COLOR_W-1:0]    color_mem [MEM_DEPTH];
  logic [DEPTH_BITS-1:0] depth_mem [MEM_DEPTH];

  state_t                state_r, state_nxt;

  logic [SIZE_W-1:0]     active_width_r, active_height_r;
  logic                  depth_en_r;
  logic [SIZE_W-1:0]     eff_w, eff_h;
  logic                  cfg_we;
  reg_idx_t              cfg_idx;

  logic [2:0]            func_r;
  logic [POS_W-1:0]      x_r, y_r;
  logic [DEPTH_BITS-1:0] z_r;
  logic [COLOR_W-1:0]    argb_r;
  logic [7:0]            shade_r;

  logic [COLOR_W-1:0]    color_rd_r;
  logic [DEPTH_BITS-1:0] depth_rd_r;
  logic [ADDR_BITS-1:0]  rd_addr, wr_addr;

  logic [X_BITS-1:0]     cx_r;
  logic [Y_BITS-1:0]     cy_r;
  logic                  last_x, last_y;
  logic                  cur_start, cur_step;

  logic                  in_acc, out_free;
  logic                  on_screen, dims_ok;
  result_t               exec_res, res_r, out_r, out_src;
  logic                  exec_col_we, exec_dep_we, clr_go;
  logic                  col_we, dep_we;
  logic [COLOR_W-1:0]    col_wdata;
  logic [DEPTH_BITS-1:0] dep_wdata;
  logic                  out_load, res_load;
  logic                  out_valid_r;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= SIZE_W'(MAX_WIDTH);
      active_height_r <= SIZE_W'(MAX_HEIGHT);
      depth_en_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACTIVE_WIDTH:  active_width_r  <= pwdata[SIZE_W-1:0];
        REG_ACTIVE_HEIGHT: active_height_r <= pwdata[SIZE_W-1:0];
        REG_DEPTH_ENABLE:  depth_en_r      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, active_width_r};
      REG_ACTIVE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, active_height_r};
      REG_DEPTH_ENABLE:  prdata = {31'b0, depth_en_r};
      default:           prdata = 32'b0;
    endcase
  end

  assign eff_w = (active_width_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : active_width_r;
  assign eff_h = (active_height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : active_height_r;
  assign dims_ok = (eff_w != '0) && (eff_h != '0);

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Item registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_func;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      z_r     <= in_new_depth[DEPTH_BITS-1:0];
      argb_r  <= {in_alpha, in_red, in_green, in_blue};
      shade_r <= in_shade;
    end
  end

  // Memories.
  assign rd_addr = {in_pos_y[Y_BITS-1:0], in_pos_x[X_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      color_rd_r <= color_mem[rd_addr];
    end
    if (col_we) begin
      color_mem[wr_addr] <= col_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      depth_rd_r <= depth_mem[rd_addr];
    end
    if (dep_we) begin
      depth_mem[wr_addr] <= dep_wdata;
    end
  end

  // Operation decode against the stored entry.
  assign on_screen = (x_r < {1'b0, eff_w}) && (y_r < {1'b0, eff_h});

  always_comb begin
    exec_res    = '0;
    exec_col_we = 1'b0;
    exec_dep_we = 1'b0;
    clr_go      = 1'b0;
    unique case (func_r)
      FN_WRITE: begin
        if (on_screen) begin
          exec_col_we = 1'b1;
        end else begin
          exec_res.status = ST_OFF;
        end
      end
      FN_ZWRITE: begin
        if (!depth_en_r) begin
          exec_res.status = ST_NOZ;
        end else if (!on_screen) begin
          exec_res.status = ST_OFF;
        end else if (z_r < depth_rd_r) begin
          exec_col_we = 1'b1;
          exec_dep_we = 1'b1;
        end else begin
          exec_res.status = ST_ZFAIL;
        end
      end
      FN_READ: begin
        if (on_screen) begin
          exec_res.color = color_rd_r;
          exec_res.depth = depth_en_r ? depth_rd_r : '0;
        end else begin
          exec_res.status = ST_OFF;
        end
      end
      FN_CLR_COL: begin
        clr_go = dims_ok;
      end
      FN_CLR_Z: begin
        if (depth_en_r) begin
          clr_go = dims_ok;
        end else begin
          exec_res.status = ST_NOZ;
        end
      end
      default: ;
    endcase
  end

  // Clear cursor.
  assign last_x = ({1'b0, cx_r} == SIZE_W'(eff_w - SIZE_W'(1)));
  assign last_y = ({1'b0, cy_r} == SIZE_W'(eff_h - SIZE_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cur_start) begin
      cx_r <= '0;
      cy_r <= '0;
    end else if (cur_step) begin
      if (last_x) begin
        cx_r <= '0;
        cy_r <= last_y ? '0 : Y_BITS'(cy_r + 1'b1);
      end else begin
        cx_r <= X_BITS'(cx_r + 1'b1);
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_we    = 1'b0;
    dep_we    = 1'b0;
    col_wdata = argb_r;
    dep_wdata = z_r;
    wr_addr   = {y_r[Y_BITS-1:0], x_r[X_BITS-1:0]};
    out_load  = 1'b0;
    res_load  = 1'b0;
    cur_start = 1'b0;
    cur_step  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        col_we = exec_col_we;
        dep_we = exec_dep_we;
        if (clr_go) begin
          res_load  = 1'b1;
          cur_start = 1'b1;
          state_nxt = S_CLEAR;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          res_load  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        wr_addr   = {cy_r, cx_r};
        col_wdata = {ALPHA_OPAQUE, shade_r, shade_r, shade_r};
        dep_wdata = DEPTH_MAX;
        col_we    = (func_r == FN_CLR_COL);
        dep_we    = (func_r == FN_CLR_Z);
        cur_step  = 1'b1;
        if (last_x && last_y) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result holding and output registers.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= exec_res;
    end
  end

  assign out_src = (state_r == S_DONE) ? res_r : exec_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_src;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_alpha  = out_r.color[31:24];
  assign out_red    = out_r.color[23:16];
  assign out_green  = out_r.color[15:8];
  assign out_blue   = out_r.color[7:0];
  assign out_depth  = 24'(out_r.depth);

  // Checks.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (col_we || dep_we) |-> (state_r != S_IDLE))
    else $error("store written while idle");

  a_depth_write_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    dep_we |-> depth_en_r)
    else $error("depth store written while depth is disabled");

  a_test_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && func_r == FN_ZWRITE && col_we) |-> (z_r < depth_rd_r))
    else $error("depth-tested write stored without passing the test");

  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (({1'b0, cx_r} < eff_w) && ({1'b0, cy_r} < eff_h)))
    else $error("clear cursor left the active area");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over an untaken word");

endmodule

// ===== sim/pixel_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_store_checker
// Watches the word and register ports of the depth-tested pixel store, keeps
// its own copy of the color and depth frames, predicts every result word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pixel_store_checker
  import dtps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_func,
  input  logic [POS_W-1:0]  in_pos_x,
  input  logic [POS_W-1:0]  in_pos_y,
  input  logic [23:0]       in_new_depth,
  input  logic [7:0]        in_alpha,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic [7:0]        in_shade,

  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic [7:0]        out_alpha,
  input  logic [7:0]        out_red,
  input  logic [7:0]        out_green,
  input  logic [7:0]        out_blue,
  input  logic [23:0]       out_depth,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,

  output int                err_count,
  output int                pending
);

  logic [COLOR_W-1:0]    frame_color [MEM_DEPTH];
  logic [DEPTH_BITS-1:0] frame_depth [MEM_DEPTH];
  logic [SIZE_W-1:0]     act_w;
  logic [SIZE_W-1:0]     act_h;
  logic                  z_en;
  result_t               results_due [$];
  int                    n_bad;

  task automatic fill_frame(bit is_depth, logic [COLOR_W-1:0] value);
    int unsigned ew;
    int unsigned eh;
    int unsigned xx;
    int unsigned yy;
    ew = (act_w > MAX_WIDTH) ? MAX_WIDTH : act_w;
    eh = (act_h > MAX_HEIGHT) ? MAX_HEIGHT : act_h;
    for (yy = 0; yy < eh; yy++) begin
      for (xx = 0; xx < ew; xx++) begin
        if (is_depth) begin
          frame_depth[yy * MAX_WIDTH + xx] = value[DEPTH_BITS-1:0];
        end else begin
          frame_color[yy * MAX_WIDTH + xx] = value;
        end
      end
    end
  endtask

  task automatic predict_pixel_op();
    result_t           r;
    int unsigned       ew;
    int unsigned       eh;
    int unsigned       a;
    bit                on_scr;
    logic [COLOR_W-1:0] argb;
    ew = (act_w > MAX_WIDTH) ? MAX_WIDTH : act_w;
    eh = (act_h > MAX_HEIGHT) ? MAX_HEIGHT : act_h;
    on_scr = (in_pos_x < ew) && (in_pos_y < eh);
    a = (in_pos_y * MAX_WIDTH + in_pos_x) % MEM_DEPTH;
    argb = {in_alpha, in_red, in_green, in_blue};
    r = '0;
    r.status = ST_DONE;
    case (in_func)
      FN_WRITE: begin
        if (on_scr) frame_color[a] = argb;
        else r.status = ST_OFF;
      end
      FN_ZWRITE: begin
        if (!z_en) begin
          r.status = ST_NOZ;
        end else if (!on_scr) begin
          r.status = ST_OFF;
        end else if (in_new_depth < frame_depth[a]) begin
          frame_depth[a] = in_new_depth;
          frame_color[a] = argb;
        end else begin
          r.status = ST_ZFAIL;
        end
      end
      FN_READ: begin
        if (on_scr) begin
          r.color = frame_color[a];
          r.depth = z_en ? frame_depth[a] : '0;
        end else begin
          r.status = ST_OFF;
        end
      end
      FN_CLR_COL: begin
        fill_frame(1'b0, {ALPHA_OPAQUE, in_shade, in_shade, in_shade});
      end
      FN_CLR_Z: begin
        if (z_en) fill_frame(1'b1, COLOR_W'(DEPTH_MAX));
        else r.status = ST_NOZ;
      end
      default: begin
      end
    endcase
    results_due.push_back(r);
  endtask

  task automatic check_result();
    result_t e;
    if (results_due.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("result word with nothing outstanding: status %0d argb %02h%02h%02h%02h",
                 out_status, out_alpha, out_red, out_green, out_blue);
      end
      return;
    end
    e = results_due.pop_front();
    if (out_status !== e.status || out_alpha !== e.color[31:24] ||
        out_red !== e.color[23:16] || out_green !== e.color[15:8] ||
        out_blue !== e.color[7:0] || out_depth !== e.depth) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("mismatch: expected status %0d argb %08h depth %06h", e.status, e.color,
                 e.depth);
        $display("          got      status %0d argb %02h%02h%02h%02h depth %06h",
                 out_status, out_alpha, out_red, out_green, out_blue, out_depth);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      act_w = SIZE_W'(MAX_WIDTH);
      act_h = SIZE_W'(MAX_HEIGHT);
      z_en = 1'b0;
      n_bad = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_pixel_op();
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_ACTIVE_WIDTH:  act_w = pwdata[SIZE_W-1:0];
          REG_ACTIVE_HEIGHT: act_h = pwdata[SIZE_W-1:0];
          REG_DEPTH_ENABLE:  z_en = pwdata[0];
          default: begin
          end
        endcase
      end
    end
    err_count <= n_bad;
    pending <= results_due.size();
  end

endmodule

// ===== sim/tb_depth_tested_pixel_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_tested_pixel_store_unit
// Drives the depth-tested pixel store with directed words and bursts of random
// words over a range of active sizes and depth settings, stalls the result
// side on a changing pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_depth_tested_pixel_store_unit;
  import dtps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          N_PHASES    = 10;
  localparam int          PHASE_WORDS = 170;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_func = '0;
  logic [POS_W-1:0]  in_pos_x = '0;
  logic [POS_W-1:0]  in_pos_y = '0;
  logic [23:0]       in_new_depth = '0;
  logic [7:0]        in_alpha = '0;
  logic [7:0]        in_red = '0;
  logic [7:0]        in_green = '0;
  logic [7:0]        in_blue = '0;
  logic [7:0]        in_shade = '0;

  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic [7:0]        out_alpha;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic [23:0]       out_depth;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                err_count;
  int                pending;

  logic              rx_pat = 1'b0;
  logic              rx_hold = 1'b0;
  logic [1:0]        rx_mode = '0;
  int unsigned       rx_left = 0;
  logic [2:0]        rx_phase = '0;

  int unsigned       cycles = 0;
  int                n_sent = 0;
  int unsigned       burst_left = 0;
  int unsigned       cur_w = MAX_WIDTH;
  int unsigned       cur_h = MAX_HEIGHT;

  int unsigned       ph_w [N_PHASES] = '{4, 16, 1, 256, 511, 1, 0, 9, 32, 7};
  int unsigned       ph_h [N_PHASES] = '{3, 16, 1, 256, 2, 511, 7, 0, 8, 5};
  bit                ph_z [N_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 0, 0, 1};

  depth_tested_pixel_store_unit dut (.*);

  pixel_store_checker checker_i (.*);

  always #2 clk = ~clk;

  assign out_stall = rx_pat | rx_hold;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 3'd1;
    if (rx_left == 0) begin
      rx_mode <= 2'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      2'd0: rx_pat <= 1'b0;
      2'd1: rx_pat <= 1'($urandom_range(0, 1));
      2'd2: rx_pat <= (rx_phase < 3'd3);
      default: rx_pat <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // The result side holds off for a long stretch so the block backs up.
  initial begin
    wait (n_sent >= 260);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send(logic [2:0] fn, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [23:0] z, logic [31:0] argb, logic [7:0] sh);
    in_valid <= 1'b1;
    in_func <= fn;
    in_pos_x <= x;
    in_pos_y <= y;
    in_new_depth <= z;
    {in_alpha, in_red, in_green, in_blue} <= argb;
    in_shade <= sh;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int unsigned val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & 32'hFFFF_FE00) | val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, bit zen);
    drain();
    reg_write(REG_ACTIVE_WIDTH, w);
    reg_write(REG_ACTIVE_HEIGHT, h);
    reg_write(REG_DEPTH_ENABLE, zen);
    cur_w = w;
    cur_h = h;
  endtask

  task automatic send_random();
    logic [2:0]       fn;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [23:0]      z;
    int unsigned      ew;
    int unsigned      eh;
    int unsigned      r;
    ew = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    eh = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
    r = $urandom_range(0, 99);
    if (r < 22) fn = FN_WRITE;
    else if (r < 52) fn = FN_ZWRITE;
    else if (r < 84) fn = FN_READ;
    else if (r < 88) fn = FN_CLR_COL;
    else if (r < 92) fn = FN_CLR_Z;
    else fn = 3'($urandom_range(0, 7));
    // Clears over a large frame are slow; they are covered by the directed part.
    if (ew * eh > 1024 && (fn == FN_CLR_COL || fn == FN_CLR_Z)) fn = FN_READ;
    if (ew == 0 || eh == 0 || $urandom_range(0, 9) == 0) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end else begin
      x = POS_W'($urandom_range(0, ew - 1));
      y = POS_W'($urandom_range(0, eh - 1));
    end
    case ($urandom_range(0, 5))
      3: z = 24'($urandom_range(0, 15));
      4: z = DEPTH_MAX;
      5: z = DEPTH_MAX - 24'($urandom_range(0, 3));
      default: z = 24'($urandom);
    endcase
    send(fn, x, y, z, $urandom, 8'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-frame clears first, so every stored entry is defined before use.
    set_frame(MAX_WIDTH, MAX_HEIGHT, 1'b1);
    send(FN_CLR_COL, 0, 0, 0, 32'h0, 8'h00);
    send(FN_CLR_Z, 0, 0, 0, 32'h0, 8'h00);

    send(FN_WRITE, 0, 0, 24'h0, 32'h0000_0000, 8'h00);
    send(FN_READ, 0, 0, 24'h0, 32'h0, 8'h00);
    send(FN_WRITE, 255, 255, DEPTH_MAX, 32'hFFFF_FFFF, 8'hFF);
    send(FN_READ, 255, 255, 24'h0, 32'h0, 8'h00);
    send(FN_WRITE, 256, 0, 24'h0, 32'h1234_5678, 8'h00);
    send(FN_READ, 1023, 1023, 24'h0, 32'h0, 8'h00);
    send(FN_ZWRITE, 5, 5, 24'h12_3456, 32'hA1B2_C3D4, 8'h00);
    send(FN_ZWRITE, 5, 5, 24'h12_3456, 32'h1111_1111, 8'h00);
    send(FN_ZWRITE, 5, 5, 24'h12_3457, 32'h2222_2222, 8'h00);
    send(FN_ZWRITE, 5, 5, 24'h0, 32'h3333_3333, 8'h00);
    send(FN_READ, 5, 5, 24'h0, 32'h0, 8'h00);
    send(FN_ZWRITE, 255, 0, DEPTH_MAX, 32'h4444_4444, 8'h00);
    send(FN_ZWRITE, 255, 0, DEPTH_MAX - 24'd1, 32'h5555_5555, 8'h00);
    send(FN_ZWRITE, 300, 2, 24'h1, 32'h6666_6666, 8'h00);
    send(3'd5, 10'($urandom), 10'($urandom), 24'($urandom), $urandom, 8'($urandom));
    send(3'd6, 10'($urandom), 10'($urandom), 24'($urandom), $urandom, 8'($urandom));
    send(3'd7, 10'($urandom), 10'($urandom), 24'($urandom), $urandom, 8'($urandom));

    set_frame(MAX_WIDTH, MAX_HEIGHT, 1'b0);
    send(FN_ZWRITE, 1, 1, 24'h7, 32'h7777_7777, 8'h00);
    send(FN_ZWRITE, 999, 999, 24'h7, 32'h7777_7777, 8'h00);
    send(FN_CLR_Z, 0, 0, 24'h0, 32'h0, 8'h00);
    send(FN_READ, 5, 5, 24'h0, 32'h0, 8'h00);

    set_frame(2, 3, 1'b1);
    send(FN_CLR_COL, 0, 0, 24'h0, 32'h0, 8'h5A);
    send(FN_READ, 1, 2, 24'h0, 32'h0, 8'h00);
    send(FN_READ, 2, 0, 24'h0, 32'h0, 8'h00);

    set_frame(0, 4, 1'b1);
    send(FN_CLR_COL, 0, 0, 24'h0, 32'h0, 8'hC3);
    send(FN_WRITE, 0, 0, 24'h0, 32'h8888_8888, 8'h00);

    for (int p = 0; p < N_PHASES; p++) begin
      set_frame(ph_w[p], ph_h[p], ph_z[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i == PHASE_WORDS / 2) drain();
        send_random();
      end
    end

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== depth_tested_pixel_store_unit.f =====
rtl/dtps_pkg.sv
rtl/depth_tested_pixel_store_unit.sv
sim/pixel_store_checker.sv
sim/tb_depth_tested_pixel_store_unit.sv
